FILE: design/agc_pkg.sv
package agc_pkg;

    // Letters a..z; the histogram has one bin per letter.
    localparam int ALPHABET_SIZE = 26;

    // Defaults for the top-level parameters.
    localparam int MAX_GROUPS_DEF  = 16;
    localparam int MAX_LEN_DEF     = 63;
    localparam int MAX_STRINGS_DEF = 256;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    typedef struct packed {
        logic [4:0] letter;
        logic       carries_letter;
        logic       last_of_string;
        logic       first_of_batch;
    } agc_in_t;

    typedef struct packed {
        logic [3:0] group_index;
        logic       is_new_group;
        logic [8:0] member_count;
        logic [4:0] groups_used;
        logic [1:0] status;
    } agc_out_t;

    // Controller to datapath.
    typedef struct packed {
        logic take;       // capture the input item into the histogram
        logic scan_init;  // restart the group search
        logic scan_step;  // advance the group search by one step
        logic load_out;   // move the finished result into the output register
    } agc_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic in_last;    // offered item ends a string
        logic scan_done;  // result captured this cycle
        logic out_free;   // output register can take a result
    } agc_sts_t;

endpackage

FILE: design/agc_ctrl.sv
module agc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  agc_pkg::agc_sts_t sts,
    output agc_pkg::agc_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take = 1'b1;
                    if (sts.in_last) begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/agc_datapath.sv
module agc_datapath #(
    parameter int MAX_GROUPS  = agc_pkg::MAX_GROUPS_DEF,
    parameter int MAX_LEN     = agc_pkg::MAX_LEN_DEF,
    parameter int MAX_STRINGS = agc_pkg::MAX_STRINGS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  agc_pkg::agc_in_t  s_data,
    input  agc_pkg::agc_cmd_t cmd,
    output agc_pkg::agc_sts_t sts,
    output logic              m_valid,
    input  logic              m_ready,
    output agc_pkg::agc_out_t m_data
);

    localparam int ALPHA     = agc_pkg::ALPHABET_SIZE;
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int GRP_CNT_W = $clog2(MAX_GROUPS + 1);
    localparam int GRP_IDX_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int MEMB_W    = $clog2(MAX_STRINGS + 1);
    localparam int SIG_W     = ALPHA * CNT_W;
    localparam int ROW_W     = MEMB_W + SIG_W;

    // Current string
    logic [CNT_W-1:0]     hist_reg [ALPHA];
    logic [CNT_W-1:0]     hist_next [ALPHA];
    logic [CNT_W-1:0]     len_reg;
    logic [CNT_W-1:0]     len_next;
    logic                 ovf_reg;
    logic                 ovf_next;
    logic [SIG_W-1:0]     hist_flat;

    // Group table: one row per group, member count above the signature
    logic [ROW_W-1:0]     table_mem [MAX_GROUPS];
    logic [ROW_W-1:0]     rd_row_reg;
    logic                 rd_en;
    logic                 wr_en;
    logic [GRP_IDX_W-1:0] wr_addr;
    logic [ROW_W-1:0]     wr_row;
    logic [MEMB_W-1:0]    rd_memb;
    logic [SIG_W-1:0]     rd_sig;
    logic [MEMB_W-1:0]    memb_inc;

    logic [GRP_CNT_W-1:0] open_reg;
    logic [GRP_CNT_W-1:0] open_next;
    logic [GRP_CNT_W-1:0] open_inc;

    // Search pipeline: address issued, then compare in the cycle after
    logic [GRP_CNT_W-1:0] rd_idx_reg;
    logic [GRP_CNT_W-1:0] rd_idx_next;
    logic                 cmp_valid_reg;
    logic                 cmp_valid_next;
    logic [GRP_IDX_W-1:0] cmp_idx_reg;
    logic [GRP_IDX_W-1:0] cmp_idx_next;
    logic                 match;
    logic                 scan_done;

    agc_pkg::agc_out_t    res_reg;
    agc_pkg::agc_out_t    res_next;
    agc_pkg::agc_out_t    out_reg;
    logic                 m_valid_reg;

    // Item capture
    logic                 letter_ok;
    logic                 at_limit;
    logic [CNT_W-1:0]     len_base;

    assign rd_memb  = rd_row_reg[ROW_W-1:SIG_W];
    assign rd_sig   = rd_row_reg[SIG_W-1:0];
    assign match    = (rd_sig == hist_flat);
    assign memb_inc = (rd_memb < MEMB_W'(MAX_STRINGS)) ? rd_memb + MEMB_W'(1) : rd_memb;
    assign open_inc = open_reg + GRP_CNT_W'(1);

    assign letter_ok = s_data.carries_letter && (s_data.letter < 5'(ALPHA));
    assign len_base  = s_data.first_of_batch ? '0 : len_reg;
    assign at_limit  = (len_base >= CNT_W'(MAX_LEN));

    always_comb begin
        for (int i = 0; i < ALPHA; i++) begin
            hist_flat[i*CNT_W +: CNT_W] = hist_reg[i];
        end
    end

    always_comb begin
        hist_next      = hist_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        open_next      = open_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        res_next       = res_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_row         = '0;
        scan_done      = 1'b0;

        if (cmd.take) begin
            // Batch start drops the open groups and any partial string
            if (s_data.first_of_batch) begin
                open_next = '0;
            end
            for (int i = 0; i < ALPHA; i++) begin
                hist_next[i] = (s_data.first_of_batch ? '0 : hist_reg[i])
                    + CNT_W'(letter_ok && !at_limit && (s_data.letter == 5'(i)));
            end
            len_next = len_base + CNT_W'(letter_ok && !at_limit);
            ovf_next = (ovf_reg && !s_data.first_of_batch) || (letter_ok && at_limit);
        end

        if (cmd.scan_init) begin
            rd_idx_next    = '0;
            cmp_valid_next = 1'b0;
        end

        if (cmd.scan_step) begin
            if (ovf_reg) begin
                scan_done = 1'b1;
                res_next  = '{group_index: '0, is_new_group: 1'b0, member_count: '0,
                              groups_used: 5'(open_reg),
                              status: agc_pkg::STATUS_TOO_LONG};
            end else if (cmp_valid_reg && match) begin
                scan_done = 1'b1;
                wr_en     = 1'b1;
                wr_addr   = cmp_idx_reg;
                wr_row    = {memb_inc, rd_sig};
                res_next  = '{group_index: 4'(cmp_idx_reg), is_new_group: 1'b0,
                              member_count: 9'(memb_inc),
                              groups_used: 5'(open_reg),
                              status: agc_pkg::STATUS_OK};
            end else if (!cmp_valid_reg && (rd_idx_reg >= open_reg)) begin
                scan_done = 1'b1;
                if (open_reg < GRP_CNT_W'(MAX_GROUPS)) begin
                    wr_en     = 1'b1;
                    wr_addr   = open_reg[GRP_IDX_W-1:0];
                    wr_row    = {MEMB_W'(1), hist_flat};
                    open_next = open_inc;
                    res_next  = '{group_index: 4'(open_reg), is_new_group: 1'b1,
                                  member_count: 9'd1,
                                  groups_used: 5'(open_inc),
                                  status: agc_pkg::STATUS_OK};
                end else begin
                    res_next  = '{group_index: '0, is_new_group: 1'b0, member_count: '0,
                                  groups_used: 5'(open_reg),
                                  status: agc_pkg::STATUS_FULL};
                end
            end else if (rd_idx_reg < open_reg) begin
                rd_en          = 1'b1;
                rd_idx_next    = rd_idx_reg + GRP_CNT_W'(1);
                cmp_valid_next = 1'b1;
                cmp_idx_next   = rd_idx_reg[GRP_IDX_W-1:0];
            end else begin
                cmp_valid_next = 1'b0;
            end

            // Drop the finished string once its result is captured
            if (scan_done) begin
                for (int i = 0; i < ALPHA; i++) begin
                    hist_next[i] = '0;
                end
                len_next = '0;
                ovf_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= wr_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_row_reg <= table_mem[rd_idx_reg[GRP_IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ALPHA; i++) begin
                hist_reg[i] <= '0;
            end
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            open_reg      <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            hist_reg      <= hist_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            open_reg      <= open_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
        if (cmd.load_out) begin
            out_reg <= res_reg;
        end
    end

    assign sts.scan_done = scan_done;
    assign sts.in_last   = s_data.last_of_string;
    assign sts.out_free  = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_data        = out_reg;

endmodule

FILE: design/anagram_group_classifier.sv
// Anagram group classifier. Strings arrive one letter per item on the s_ channel
// (letter a=0..z=25 with carries_letter set; an item with carries_letter clear
// adds nothing, which is how an empty string is sent). The block keeps a letter
// histogram of the string in flight; at the item marked last_of_string it looks
// the histogram up in a table of up to MAX_GROUPS group signatures and emits one
// result item on the m_ channel: the group index, whether a new group was opened,
// the group's member count (saturating at MAX_STRINGS), the number of open groups
// and a status (ok, table full, or string longer than MAX_LEN; the last two are
// not inserted). first_of_batch empties the table and drops any partial string.
// Flow: an item that does not end a string is taken at once. An item that ends
// a string starts the search: the signature table is a single-port memory read
// one row per cycle with a registered read, so a hit on group g stops after row
// g is compared, a miss reads all open groups (none when no group is open), and
// an over-long string skips the search. The next item is taken once the result
// sits in the output register, which holds it until m_ready.
module anagram_group_classifier #(
    parameter int MAX_GROUPS  = agc_pkg::MAX_GROUPS_DEF,
    parameter int MAX_LEN     = agc_pkg::MAX_LEN_DEF,
    parameter int MAX_STRINGS = agc_pkg::MAX_STRINGS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  agc_pkg::agc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output agc_pkg::agc_out_t m_data
);

    // Command and status between the sequencer and the datapath
    agc_pkg::agc_cmd_t cmd;
    agc_pkg::agc_sts_t sts;

    // Sequencer: take items, run the group search, hand off the result
    agc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Histogram, group table, search pipeline and output register
    agc_datapath #(
        .MAX_GROUPS  (MAX_GROUPS),
        .MAX_LEN     (MAX_LEN),
        .MAX_STRINGS (MAX_STRINGS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: test/anagram_group_classifier_tb.sv
`timescale 1ns / 1ps

module anagram_group_classifier_tb;

    localparam int MAX_GROUPS  = agc_pkg::MAX_GROUPS_DEF;
    localparam int MAX_LEN     = agc_pkg::MAX_LEN_DEF;
    localparam int MAX_STRINGS = agc_pkg::MAX_STRINGS_DEF;

    localparam int RANDOM_ITEMS     = 1300;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 40;
    localparam int CYCLE_LIMIT      = 1_500_000;

    localparam logic [4:0] LTR_A = 5'd0;
    localparam logic [4:0] LTR_B = 5'd1;
    localparam logic [4:0] LTR_C = 5'd2;
    localparam logic [4:0] LTR_Z = 5'd25;
    localparam logic [4:0] LTR_FIRST_BAD = 5'd26;
    localparam logic [4:0] LTR_TOP = 5'd31;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    agc_pkg::agc_in_t   s_data;
    logic               m_valid;
    logic               m_ready;
    agc_pkg::agc_out_t  m_data;

    anagram_group_classifier dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Directed script: each row sends its item reps times. A pinned row carries
    // the result expected from its final rep, read straight off the behavior.
    typedef struct {
        agc_pkg::agc_in_t  item;
        int                reps;
        bit                pinned;
        agc_pkg::agc_out_t want;
    } script_row_t;

    script_row_t script[$];

    // Predicted results, oldest first, still waiting to come out of the block.
    agc_pkg::agc_out_t results_due[$];

    // Shadow of the block's state.
    logic [5:0] hist      [agc_pkg::ALPHABET_SIZE];
    logic [6:0] str_len;
    logic       str_over;
    logic [5:0] sig_rows  [MAX_GROUPS][agc_pkg::ALPHABET_SIZE];
    logic [8:0] group_size[MAX_GROUPS];
    logic [4:0] groups_open;

    int  mismatch_count = 0;
    int  items_sent = 0;
    int  cycle_count = 0;
    bit  sink_hold_req = 1'b0;

    function automatic agc_pkg::agc_in_t stim(input logic [4:0] ltr, input logic carries,
                                              input logic last, input logic first);
        agc_pkg::agc_in_t d;
        d.letter         = ltr;
        d.carries_letter = carries;
        d.last_of_string = last;
        d.first_of_batch = first;
        return d;
    endfunction

    function automatic agc_pkg::agc_out_t res(input int gidx, input logic fresh,
                                              input int cnt, input int used,
                                              input logic [1:0] st);
        agc_pkg::agc_out_t r;
        r.group_index  = gidx[3:0];
        r.is_new_group = fresh;
        r.member_count = cnt[8:0];
        r.groups_used  = used[4:0];
        r.status       = st;
        return r;
    endfunction

    function automatic void drop_string();
        for (int i = 0; i < agc_pkg::ALPHABET_SIZE; i++) hist[i] = '0;
        str_len  = '0;
        str_over = 1'b0;
    endfunction

    // Fold one item into the shadow state; return 1 with the result when the
    // item ends a string.
    function automatic bit fold_item(input agc_pkg::agc_in_t d,
                                     output agc_pkg::agc_out_t r);
        int  g;
        int  hit;
        bit  same;
        r   = '0;
        hit = -1;
        if (d.first_of_batch) begin
            groups_open = '0;
            drop_string();
        end
        if (d.carries_letter && d.letter < agc_pkg::ALPHABET_SIZE) begin
            if (str_len >= MAX_LEN) begin
                str_over = 1'b1;
            end else begin
                str_len++;
                hist[d.letter]++;
            end
        end
        if (!d.last_of_string) return 1'b0;

        if (str_over) begin
            r.status = agc_pkg::STATUS_TOO_LONG;
        end else begin
            for (g = 0; g < groups_open && hit < 0; g++) begin
                same = 1'b1;
                for (int i = 0; i < agc_pkg::ALPHABET_SIZE; i++)
                    if (sig_rows[g][i] != hist[i]) same = 1'b0;
                if (same) hit = g;
            end
            if (hit >= 0) begin
                if (group_size[hit] < MAX_STRINGS) group_size[hit]++;
                r.group_index  = hit[3:0];
                r.member_count = group_size[hit];
            end else if (groups_open < MAX_GROUPS) begin
                for (int i = 0; i < agc_pkg::ALPHABET_SIZE; i++)
                    sig_rows[groups_open[3:0]][i] = hist[i];
                group_size[groups_open[3:0]] = 9'd1;
                r.group_index  = groups_open[3:0];
                r.is_new_group = 1'b1;
                r.member_count = 9'd1;
                groups_open++;
            end else begin
                r.status = agc_pkg::STATUS_FULL;
            end
        end
        r.groups_used = groups_open;
        drop_string();
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string field, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // Offer one item and hold it until accepted. Valid stays high on return so
    // that a back-to-back item does not drop it within the same step.
    task automatic offer_item(input agc_pkg::agc_in_t d, input bit pinned,
                              input agc_pkg::agc_out_t want);
        agc_pkg::agc_out_t calc;
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (fold_item(d, calc)) results_due.push_back(pinned ? want : calc);
    endtask

    // Insert a sender gap: mostly none, sometimes short, rarely long.
    task automatic pace(input bit burst);
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (burst || pick < 60) n = 0;
        else if (pick < 96) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 40);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Send one string of len letters drawn from base .. base+alpha-1. Noise
    // adds ignored items, a stray batch start, or an end mark on an ignored item.
    task automatic send_string(input int len, input int alpha, input int base,
                               input bit new_batch, input bit noisy, input bit burst);
        agc_pkg::agc_in_t d;
        bit               tail_mark;
        tail_mark = noisy && ($urandom_range(0, 9) == 0);
        if (len == 0) begin
            d = stim(5'($urandom_range(0, 31)), 1'b0, 1'b1, new_batch);
            offer_item(d, 1'b0, '0);
            pace(burst);
            return;
        end
        for (int i = 0; i < len; i++) begin
            if (noisy && $urandom_range(0, 19) == 0) begin
                if ($urandom_range(0, 1))
                    d = stim(5'($urandom_range(LTR_FIRST_BAD, LTR_TOP)), 1'b1, 1'b0, 1'b0);
                else
                    d = stim(5'($urandom_range(0, 31)), 1'b0, 1'b0, 1'b0);
                offer_item(d, 1'b0, '0);
                pace(burst);
            end
            d = stim(5'(base + $urandom_range(0, alpha - 1)), 1'b1,
                     (i == len - 1) && !tail_mark,
                     (new_batch && i == 0) || (noisy && $urandom_range(0, 59) == 0));
            offer_item(d, 1'b0, '0);
            pace(burst);
        end
        if (tail_mark) begin
            if ($urandom_range(0, 1))
                d = stim(5'($urandom_range(LTR_FIRST_BAD, LTR_TOP)), 1'b1, 1'b1, 1'b0);
            else
                d = stim(5'($urandom_range(0, 31)), 1'b0, 1'b1, 1'b0);
            offer_item(d, 1'b0, '0);
            pace(burst);
        end
    endtask

    // Result side: check each accepted result against the oldest prediction.
    always @(posedge aclk) begin : result_check
        agc_pkg::agc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                note_mismatch("unexpected result, group_index", m_data.group_index, -1);
            end else begin
                want = results_due.pop_front();
                if (m_data.group_index !== want.group_index)
                    note_mismatch("group_index", m_data.group_index, want.group_index);
                if (m_data.is_new_group !== want.is_new_group)
                    note_mismatch("is_new_group", m_data.is_new_group, want.is_new_group);
                if (m_data.member_count !== want.member_count)
                    note_mismatch("member_count", m_data.member_count, want.member_count);
                if (m_data.groups_used !== want.groups_used)
                    note_mismatch("groups_used", m_data.groups_used, want.groups_used);
                if (m_data.status !== want.status)
                    note_mismatch("status", m_data.status, want.status);
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("anagram_group_classifier_tb NOT OK");
            $finish;
        end
    end

    // Receiver: random ready stretches and stalls, plus one long hold on request
    // so the block fills and backs up its input.
    initial begin : sink_side
        int pick;
        int n;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            pick = $urandom_range(0, 99);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge aclk);
            end else if (pick < 40) begin
                m_ready <= 1'b1;
                n = $urandom_range(1, 20);
                repeat (n) @(posedge aclk);
            end else if (pick < 52) begin
                m_ready <= 1'b1;
                n = $urandom_range(50, 150);
                repeat (n) @(posedge aclk);
            end else if (pick < 95) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 3);
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                n = $urandom_range(15, 60);
                repeat (n) @(posedge aclk);
            end
        end
    end

    initial begin : source_side
        script_row_t row;
        int          start_count;
        int          batch_no;
        int          alpha;
        int          base;
        int          nstr;
        int          pick;
        int          len;
        bit          burst;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        drop_string();
        groups_open = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed script: single letters at both ends of the alphabet, a
        // repeat hit, the empty string, ignored letters, a two-letter anagram
        // pair, the length limit from both sides, a batch start that drops a
        // partial string, and a group driven to its member count ceiling.
        script.push_back('{stim(LTR_A, 1, 1, 1), 1, 1, res(0, 1, 1, 1, agc_pkg::STATUS_OK)});
        script.push_back('{stim(LTR_Z, 1, 1, 0), 1, 1, res(1, 1, 1, 2, agc_pkg::STATUS_OK)});
        script.push_back('{stim(LTR_A, 1, 1, 0), 1, 1, res(0, 0, 2, 2, agc_pkg::STATUS_OK)});
        script.push_back('{stim(LTR_TOP, 0, 1, 0), 1, 1,
                           res(2, 1, 1, 3, agc_pkg::STATUS_OK)});
        script.push_back('{stim(LTR_FIRST_BAD, 1, 1, 0), 1, 1,
                           res(2, 0, 2, 3, agc_pkg::STATUS_OK)});
        script.push_back('{stim(LTR_TOP, 1, 0, 0), 1, 0, '0});
        script.push_back('{stim(LTR_B, 1, 1, 0), 1, 1, res(3, 1, 1, 4, agc_pkg::STATUS_OK)});
        script.push_back('{stim(LTR_A, 1, 0, 0), 1, 0, '0});
        script.push_back('{stim(LTR_B, 1, 1, 0), 1, 1, res(4, 1, 1, 5, agc_pkg::STATUS_OK)});
        script.push_back('{stim(LTR_B, 1, 0, 0), 1, 0, '0});
        script.push_back('{stim(LTR_A, 1, 1, 0), 1, 1, res(4, 0, 2, 5, agc_pkg::STATUS_OK)});
        script.push_back('{stim(LTR_Z, 1, 0, 0), MAX_LEN, 0, '0});
        script.push_back('{stim(LTR_Z, 1, 1, 0), 1, 1,
                           res(0, 0, 0, 5, agc_pkg::STATUS_TOO_LONG)});
        script.push_back('{stim(LTR_Z, 1, 0, 0), MAX_LEN - 1, 0, '0});
        script.push_back('{stim(LTR_Z, 1, 1, 0), 1, 1, res(5, 1, 1, 6, agc_pkg::STATUS_OK)});
        script.push_back('{stim(LTR_C, 1, 0, 0), 1, 0, '0});
        script.push_back('{stim(LTR_C, 1, 1, 1), 1, 1, res(0, 1, 1, 1, agc_pkg::STATUS_OK)});
        script.push_back('{stim(LTR_A, 0, 0, 1), 1, 0, '0});
        script.push_back('{stim(LTR_A, 0, 1, 0), MAX_STRINGS + 44, 1,
                           res(0, 0, MAX_STRINGS, 1, agc_pkg::STATUS_OK)});

        foreach (script[k]) begin
            row = script[k];
            for (int r = 0; r < row.reps; r++) begin
                offer_item(row.item, row.pinned && (r == row.reps - 1), row.want);
                pace(1'b0);
            end
        end

        // Fill the table with runs of 'a' of distinct lengths, overflow it,
        // then hit the first group again.
        for (int k = 0; k <= MAX_GROUPS + 1; k++)
            send_string(k + 1, 1, LTR_A, k == 0, 1'b0, 1'b0);
        send_string(1, 1, LTR_A, 1'b0, 1'b0, 1'b0);

        // Random batches over small alphabets so strings collide often.
        start_count = items_sent;
        batch_no    = 0;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 3) == 0);
            alpha = ($urandom_range(0, 19) == 0) ? agc_pkg::ALPHABET_SIZE
                                                 : $urandom_range(1, 4);
            base  = $urandom_range(0, agc_pkg::ALPHABET_SIZE - alpha);
            nstr  = $urandom_range(3, 40);
            if (batch_no == 2) sink_hold_req = 1'b1;
            if (batch_no == 5) begin
                // Pause until the block has drained every result.
                s_valid <= 1'b0;
                do @(posedge aclk); while (results_due.size() != 0);
            end
            for (int s = 0; s < nstr; s++) begin
                pick = $urandom_range(0, 99);
                if (pick < 6) len = $urandom_range(MAX_LEN - 8, MAX_LEN + 7);
                else if (pick < 14) len = 0;
                else len = $urandom_range(1, 4);
                send_string(len, alpha, base, s == 0, 1'b1, burst);
            end
            batch_no++;
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("anagram_group_classifier_tb OK");
        end else begin
            $display("anagram_group_classifier_tb NOT OK");
        end
        $finish;
    end

endmodule
